/* design/assert_macros.svh */
// Assertion macros shared by the parser RTL.
// Needs clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define TESP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define TESP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/tesp_pkg.sv */
// Types, sizes and byte codes for the terminal escape sequence parser.
// No dependencies; used by every parser module.
`default_nettype none

package tesp_pkg;

  localparam int ARG_SLOTS  = 16;
  localparam int CSI_BUF    = 64;
  localparam int STRING_BUF = 256;

  localparam int ARG_IDX_W  = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;
  localparam int ARG_CNT_W  = $clog2(ARG_SLOTS + 1);
  localparam int CSI_FILL_W = $clog2(CSI_BUF);
  localparam int STR_FILL_W = $clog2(STRING_BUF);
  localparam int ARG_W      = 17;   // colon flag on top of a 16-bit value

  localparam logic [CSI_FILL_W-1:0] CSI_FILL_LAST = CSI_FILL_W'(CSI_BUF - 1);
  localparam logic [STR_FILL_W-1:0] STR_FILL_LAST = STR_FILL_W'(STRING_BUF - 1);
  localparam logic [ARG_CNT_W-1:0]  ARG_LIMIT     = ARG_CNT_W'(ARG_SLOTS);

  localparam logic [7:0] BYTE_BEL   = 8'h07;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_VT    = 8'h0B;
  localparam logic [7:0] BYTE_FF    = 8'h0C;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7E;

  typedef enum logic [6:0] {
    MODE_GROUND = 7'b0000001,
    MODE_ESC    = 7'b0000010,
    MODE_ESCINT = 7'b0000100,
    MODE_CSI    = 7'b0001000,
    MODE_OSC    = 7'b0010000,
    MODE_DCS    = 7'b0100000,
    MODE_APC    = 7'b1000000
  } mode_t;

  typedef enum logic [3:0] {
    ACT_PRINT     = 4'd0,
    ACT_LF        = 4'd1,
    ACT_CR        = 4'd2,
    ACT_BS        = 4'd3,
    ACT_TAB       = 4'd4,
    ACT_BELL      = 4'd5,
    ACT_ESC_FINAL = 4'd6,
    ACT_CSI_ARG   = 4'd7,
    ACT_OSC_BYTE  = 4'd8,
    ACT_OSC_END   = 4'd9,
    ACT_DCS_BYTE  = 4'd10,
    ACT_DCS_END   = 4'd11
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  data_byte;
    logic [7:0]  private_marker;
    logic [7:0]  trailing_byte;
    logic [3:0]  arg_index;
    logic [15:0] arg_value;
    logic        arg_colon;
    logic [4:0]  arg_count;
    logic        bel_terminated;
    logic        last;
  } res_t;

  // argument memory write port
  typedef struct packed {
    logic                 en;
    logic [ARG_IDX_W-1:0] idx;
    logic [ARG_W-1:0]     data;
  } commit_t;

  // kick-off of argument emission on a CSI final
  typedef struct packed {
    logic                 en;
    logic [ARG_CNT_W-1:0] total;
    logic [7:0]           final_byte;
    logic [7:0]           marker;
    logic [7:0]           trailing;
  } start_t;

endpackage

`default_nettype wire

/* design/tesp_parse.sv */
// Byte-level parse state machine: modes, CSI argument accumulation, string counting.
// Depends on tesp_pkg. Emits single results, argument memory writes and emit starts.
`default_nettype none

module tesp_parse import tesp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] byte_in,
  output res_t            res,
  output logic            res_valid,
  output commit_t         commit,
  output start_t          start
);

  mode_t                 parse_mode, parse_mode_next;
  logic [CSI_FILL_W-1:0] csi_fill, csi_fill_next;
  logic [15:0]           arg_accum, arg_accum_next;
  logic                  digit_seen, digit_seen_next;
  logic                  pending_colon, pending_colon_next;
  logic [ARG_CNT_W-1:0]  arg_total, arg_total_next;
  logic [7:0]            marker_byte, marker_byte_next;
  logic [7:0]            last_buffered, last_buffered_next;
  logic [STR_FILL_W-1:0] string_fill, string_fill_next;

  logic                  room;
  logic [19:0]           acc_x10;
  logic [19:0]           acc_sum;
  logic [15:0]           acc_sat;
  action_t               str_base, str_end;

  assign room    = arg_total < ARG_LIMIT;
  assign acc_x10 = {1'b0, arg_accum, 3'b000} + {3'b000, arg_accum, 1'b0};
  assign acc_sum = acc_x10 + 20'(byte_in[3:0]);
  assign acc_sat = (|acc_sum[19:16]) ? 16'hFFFF : acc_sum[15:0];

  always_comb begin
    str_base = (parse_mode == MODE_OSC) ? ACT_OSC_BYTE : ACT_DCS_BYTE;
    str_end  = (parse_mode == MODE_OSC) ? ACT_OSC_END : ACT_DCS_END;
  end

  always_comb begin
    parse_mode_next    = parse_mode;
    csi_fill_next      = csi_fill;
    arg_accum_next     = arg_accum;
    digit_seen_next    = digit_seen;
    pending_colon_next = pending_colon;
    arg_total_next     = arg_total;
    marker_byte_next   = marker_byte;
    last_buffered_next = last_buffered;
    string_fill_next   = string_fill;

    res       = '0;
    res.last  = 1'b1;
    res_valid = 1'b0;

    commit.en   = 1'b0;
    commit.idx  = arg_total[ARG_IDX_W-1:0];
    commit.data = {pending_colon, digit_seen ? arg_accum : 16'h0000};

    start.en         = 1'b0;
    start.total      = arg_total + ARG_CNT_W'(room);
    start.final_byte = byte_in;
    start.marker     = marker_byte;
    start.trailing   = last_buffered;

    case (parse_mode)
      MODE_GROUND: begin
        if (byte_in == BYTE_ESC) begin
          parse_mode_next = MODE_ESC;
        end else if (byte_in inside {BYTE_LF, BYTE_VT, BYTE_FF}) begin
          res_valid  = 1'b1;
          res.action = ACT_LF;
        end else if (byte_in == BYTE_CR) begin
          res_valid  = 1'b1;
          res.action = ACT_CR;
        end else if (byte_in == BYTE_BS) begin
          res_valid  = 1'b1;
          res.action = ACT_BS;
        end else if (byte_in == BYTE_TAB) begin
          res_valid  = 1'b1;
          res.action = ACT_TAB;
        end else if (byte_in == BYTE_BEL) begin
          res_valid  = 1'b1;
          res.action = ACT_BELL;
        end else if (byte_in < BYTE_SPACE || byte_in == BYTE_DEL) begin
          res_valid = 1'b0;
        end else begin
          res_valid     = 1'b1;
          res.action    = ACT_PRINT;
          res.data_byte = byte_in;
        end
      end

      MODE_ESC: begin
        parse_mode_next = MODE_GROUND;
        if (byte_in == 8'h5B) begin          // '['
          parse_mode_next    = MODE_CSI;
          csi_fill_next      = '0;
          arg_accum_next     = '0;
          digit_seen_next    = 1'b0;
          pending_colon_next = 1'b0;
          arg_total_next     = '0;
          marker_byte_next   = '0;
          last_buffered_next = '0;
        end else if (byte_in == 8'h5D) begin // ']'
          parse_mode_next  = MODE_OSC;
          string_fill_next = '0;
        end else if (byte_in == 8'h50) begin // 'P'
          parse_mode_next  = MODE_DCS;
          string_fill_next = '0;
        end else if (byte_in inside {8'h5F, 8'h5E}) begin  // '_' '^'
          parse_mode_next = MODE_APC;
        end else if (byte_in inside {8'h63, 8'h37, 8'h38, 8'h44, 8'h45, 8'h4D,
                                     8'h3D, 8'h3E}) begin
          res_valid     = 1'b1;
          res.action    = ACT_ESC_FINAL;
          res.data_byte = byte_in;
        end else if (byte_in inside {8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
                                     8'h2F, 8'h23, 8'h25, 8'h20}) begin
          parse_mode_next = MODE_ESCINT;
        end
      end

      MODE_ESCINT: begin
        parse_mode_next = MODE_GROUND;
      end

      MODE_CSI: begin
        if (byte_in inside {[FINAL_LO:FINAL_HI]}) begin
          commit.en       = room;
          start.en        = 1'b1;
          parse_mode_next = MODE_GROUND;
          arg_total_next  = start.total;
        end else if (byte_in inside {8'h3F, 8'h3E, 8'h21, 8'h3D}) begin  // ? > ! =
          marker_byte_next = byte_in;
        end else if (csi_fill < CSI_FILL_LAST) begin
          csi_fill_next      = csi_fill + 1'b1;
          last_buffered_next = byte_in;
          if (byte_in inside {[8'h30:8'h39]}) begin
            arg_accum_next  = acc_sat;
            digit_seen_next = 1'b1;
          end else if (byte_in inside {8'h3B, 8'h3A}) begin  // ';' ':'
            commit.en          = room;
            arg_total_next     = start.total;
            pending_colon_next = (byte_in == 8'h3A);
            arg_accum_next     = '0;
            digit_seen_next    = 1'b0;
          end
        end else begin
          // buffer overflow: abort silently
          parse_mode_next = MODE_GROUND;
        end
      end

      MODE_OSC, MODE_DCS: begin
        if (byte_in == BYTE_BEL) begin
          parse_mode_next    = MODE_GROUND;
          res_valid          = 1'b1;
          res.action         = str_end;
          res.bel_terminated = 1'b1;
        end else if (byte_in == BYTE_ESC) begin
          parse_mode_next = MODE_ESC;
          res_valid       = 1'b1;
          res.action      = str_end;
        end else if (string_fill < STR_FILL_LAST) begin
          string_fill_next = string_fill + 1'b1;
          res_valid        = 1'b1;
          res.action       = str_base;
          res.data_byte    = byte_in;
        end
      end

      MODE_APC: begin
        if (byte_in == BYTE_BEL) begin
          parse_mode_next = MODE_GROUND;
        end else if (byte_in == BYTE_ESC) begin
          parse_mode_next = MODE_ESC;
        end
      end

      default: begin
        parse_mode_next = MODE_GROUND;
      end
    endcase

    if (!accept) begin
      res_valid = 1'b0;
      commit.en = 1'b0;
      start.en  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= MODE_GROUND;
      csi_fill      <= '0;
      arg_accum     <= '0;
      digit_seen    <= 1'b0;
      pending_colon <= 1'b0;
      arg_total     <= '0;
      marker_byte   <= '0;
      last_buffered <= '0;
      string_fill   <= '0;
    end else if (accept) begin
      parse_mode    <= parse_mode_next;
      csi_fill      <= csi_fill_next;
      arg_accum     <= arg_accum_next;
      digit_seen    <= digit_seen_next;
      pending_colon <= pending_colon_next;
      arg_total     <= arg_total_next;
      marker_byte   <= marker_byte_next;
      last_buffered <= last_buffered_next;
      string_fill   <= string_fill_next;
    end
  end

endmodule

`default_nettype wire

/* design/tesp_emit.sv */
// CSI argument memory and the sequencer that reads it back on a final byte.
// Uses tesp_pkg. One read per cycle unless stalled, read data registered.
`default_nettype none

module tesp_emit import tesp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire commit_t commit,
  input  wire start_t  start,
  input  wire logic    can_push,
  output logic         busy,
  output logic         push_valid,
  output res_t         push_res
);

  logic [ARG_W-1:0]     arg_mem [ARG_SLOTS];
  logic [ARG_W-1:0]     rd_data;

  logic                 emitting;
  logic [ARG_CNT_W-1:0] iss;        // reads issued so far
  logic                 pend;       // rd_data holds an unsent argument
  logic [ARG_IDX_W-1:0] pend_idx;
  logic [ARG_CNT_W-1:0] total;
  logic [7:0]           final_byte;
  logic [7:0]           marker;
  logic [7:0]           trailing;

  logic                 push;
  logic                 push_last;
  logic                 rd_en;

  assign push      = pend && can_push;
  assign push_last = (ARG_CNT_W'(pend_idx) + ARG_CNT_W'(1)) == total;
  assign rd_en     = emitting && (iss < total) && (!pend || push);
  assign busy      = emitting;

  // the first read comes in the cycle after start, so the last commit
  // is already in the array when it is read back
  always_ff @(posedge clk) begin
    if (commit.en) begin
      arg_mem[commit.idx] <= commit.data;
    end
    if (rd_en) begin
      rd_data <= arg_mem[iss[ARG_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      pend     <= 1'b0;
      iss      <= '0;
    end else if (start.en) begin
      emitting <= 1'b1;
      pend     <= 1'b0;
      iss      <= '0;
    end else if (emitting) begin
      if (rd_en) begin
        iss  <= iss + 1'b1;
        pend <= 1'b1;
      end else if (push) begin
        pend <= 1'b0;
      end
      if (push && push_last) begin
        emitting <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.en) begin
      total      <= start.total;
      final_byte <= start.final_byte;
      marker     <= start.marker;
      trailing   <= start.trailing;
    end
    if (rd_en) begin
      pend_idx <= iss[ARG_IDX_W-1:0];
    end
  end

  always_comb begin
    push_valid              = push;
    push_res                = '0;
    push_res.action         = ACT_CSI_ARG;
    push_res.data_byte      = final_byte;
    push_res.private_marker = marker;
    push_res.trailing_byte  = trailing;
    push_res.arg_index      = 4'(pend_idx);
    push_res.arg_value      = rd_data[15:0];
    push_res.arg_colon      = rd_data[16];
    push_res.arg_count      = 5'(total);
    push_res.bel_terminated = 1'b0;
    push_res.last           = push_last;
  end

endmodule

`default_nettype wire

/* design/terminal_escape_sequence_parser.sv */
// A result is registered in the output register, or in the skid register on a stall.
// Throughput: one byte per cycle unless stalled; a CSI final holds input while its
// N arguments leave the argument memory, one per cycle unless the output stalls.
// A waiting result sits in a skid register, so input flows while output stalls once.
// Reset: mode to ground, CSI and string state cleared; argument memory not cleared.
`default_nettype none

`include "assert_macros.svh"

module terminal_escape_sequence_parser import tesp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       action,
  output logic [7:0]       data_byte,
  output logic [7:0]       private_marker,
  output logic [7:0]       trailing_byte,
  output logic [3:0]       arg_index,
  output logic [15:0]      arg_value,
  output logic             arg_colon,
  output logic [4:0]       arg_count,
  output logic             bel_terminated,
  output logic             last
);

  logic    accept;
  res_t    parse_res;
  logic    parse_valid;
  commit_t commit;
  start_t  start;
  logic    emit_busy;
  logic    emit_valid;
  res_t    emit_res;

  res_t    new_res;
  logic    new_valid;
  res_t    out_res;
  res_t    hold_res;
  logic    hold_valid;
  logic    out_free;

  assign in_stall = emit_busy || hold_valid;
  assign accept   = in_valid && !in_stall;

  tesp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_in   (byte_in),
    .res       (parse_res),
    .res_valid (parse_valid),
    .commit    (commit),
    .start     (start)
  );

  tesp_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .commit     (commit),
    .start      (start),
    .can_push   (!hold_valid),
    .busy       (emit_busy),
    .push_valid (emit_valid),
    .push_res   (emit_res)
  );

  // parser and emitter never produce in the same cycle
  assign new_valid = parse_valid || emit_valid;
  assign new_res   = emit_valid ? emit_res : parse_res;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_valid <= new_valid;
      end
    end else if (new_valid) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= hold_valid ? hold_res : new_res;
    end else if (new_valid) begin
      hold_res <= new_res;
    end
  end

  assign action         = out_res.action;
  assign data_byte      = out_res.data_byte;
  assign private_marker = out_res.private_marker;
  assign trailing_byte  = out_res.trailing_byte;
  assign arg_index      = out_res.arg_index;
  assign arg_value      = out_res.arg_value;
  assign arg_colon      = out_res.arg_colon;
  assign arg_count      = out_res.arg_count;
  assign bel_terminated = out_res.bel_terminated;
  assign last           = out_res.last;

  `TESP_ASSERT(a_hold_behind_out, hold_valid |-> out_valid, "skid holds a request but output is empty")
  `TESP_ASSERT(a_emit_after_final, $rose(emit_busy) |-> $past(accept), "argument emission began without a final byte")
  `TESP_ASSERT(a_last_arg_count, (out_valid && out_res.action == ACT_CSI_ARG && out_res.last) |-> ((5'(out_res.arg_index) + 5'd1) == out_res.arg_count), "last argument index disagrees with count")
  `TESP_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && !hold_valid && !emit_busy), "reset left a request pending")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for terminal_escape_sequence_parser: byte stream in, actions out.
// A shadow parser predicts every action. Both handshakes idle and stall at random.
// Depends on tesp_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import tesp_pkg::*;

  // Shadow of the parser state, plus the queue of actions still owed by the block
  class parser_shadow;
    mode_t       mode;
    int          csi_fill;
    int          arg_acc;
    int          arg_total;
    int          string_fill;
    bit          digit_seen;
    bit          pending_colon;
    logic [15:0] arg_vals [ARG_SLOTS];
    bit          arg_cols [ARG_SLOTS];
    logic [7:0]  marker;
    logic [7:0]  last_buf;
    res_t        pending_actions [$];
    int          errors;

    function new();
      mode        = MODE_GROUND;
      string_fill = 0;
      errors      = 0;
      clear_csi();
    endfunction

    function void clear_csi();
      csi_fill      = 0;
      arg_acc       = 0;
      digit_seen    = 1'b0;
      pending_colon = 1'b0;
      arg_total     = 0;
      marker        = 8'h00;
      last_buf      = 8'h00;
    endfunction

    function void close_arg();
      if (arg_total < ARG_SLOTS) begin
        arg_vals[arg_total] = digit_seen ? arg_acc[15:0] : 16'h0000;
        arg_cols[arg_total] = pending_colon;
        arg_total++;
      end
    endfunction

    function void push_plain(action_t act, logic [7:0] data, bit bel);
      res_t r;
      r                = '0;
      r.action         = act;
      r.data_byte      = data;
      r.bel_terminated = bel;
      r.last           = 1'b1;
      pending_actions.push_back(r);
    endfunction

    function int outstanding();
      return pending_actions.size();
    endfunction

    // called once per accepted request
    function void take_byte(logic [7:0] b);
      int      k;
      res_t    r;
      action_t byte_act;
      action_t end_act;
      case (mode)
        MODE_GROUND: begin
          case (b)
            BYTE_ESC: mode = MODE_ESC;
            BYTE_LF, BYTE_VT, BYTE_FF: push_plain(ACT_LF, 8'h00, 1'b0);
            BYTE_CR: push_plain(ACT_CR, 8'h00, 1'b0);
            BYTE_BS: push_plain(ACT_BS, 8'h00, 1'b0);
            BYTE_TAB: push_plain(ACT_TAB, 8'h00, 1'b0);
            BYTE_BEL: push_plain(ACT_BELL, 8'h00, 1'b0);
            default: begin
              if (b >= BYTE_SPACE && b != BYTE_DEL) push_plain(ACT_PRINT, b, 1'b0);
            end
          endcase
        end
        MODE_ESC: begin
          mode = MODE_GROUND;
          case (b)
            "[": begin
              clear_csi();
              mode = MODE_CSI;
            end
            "]": begin
              string_fill = 0;
              mode = MODE_OSC;
            end
            "P": begin
              string_fill = 0;
              mode = MODE_DCS;
            end
            "_", "^": mode = MODE_APC;
            "c", "7", "8", "D", "E", "M", "=", ">": push_plain(ACT_ESC_FINAL, b, 1'b0);
            "(", ")", "*", "+", "-", ".", "/", "#", "%", " ": mode = MODE_ESCINT;
            default: ;
          endcase
        end
        MODE_ESCINT: mode = MODE_GROUND;
        MODE_CSI: begin
          if (b >= FINAL_LO && b <= FINAL_HI) begin
            close_arg();
            mode = MODE_GROUND;
            for (k = 0; k < arg_total; k++) begin
              r                = '0;
              r.action         = ACT_CSI_ARG;
              r.data_byte      = b;
              r.private_marker = marker;
              r.trailing_byte  = last_buf;
              r.arg_index      = k[3:0];
              r.arg_value      = arg_vals[k];
              r.arg_colon      = arg_cols[k];
              r.arg_count      = arg_total[4:0];
              r.last           = (k + 1 == arg_total);
              pending_actions.push_back(r);
            end
          end else if (b == "?" || b == ">" || b == "!" || b == "=") begin
            marker = b;
          end else if (csi_fill + 1 < CSI_BUF) begin
            csi_fill++;
            last_buf = b;
            if (b >= "0" && b <= "9") begin
              arg_acc = arg_acc * 10 + (b - "0");
              if (arg_acc > 65535) arg_acc = 65535;
              digit_seen = 1'b1;
            end else if (b == ";" || b == ":") begin
              close_arg();
              pending_colon = (b == ":");
              arg_acc       = 0;
              digit_seen    = 1'b0;
            end
          end else begin
            mode = MODE_GROUND;   // buffer full: sequence dropped
          end
        end
        MODE_OSC, MODE_DCS: begin
          if (mode == MODE_OSC) begin
            byte_act = ACT_OSC_BYTE;
            end_act  = ACT_OSC_END;
          end else begin
            byte_act = ACT_DCS_BYTE;
            end_act  = ACT_DCS_END;
          end
          if (b == BYTE_BEL) begin
            mode = MODE_GROUND;
            push_plain(end_act, 8'h00, 1'b1);
          end else if (b == BYTE_ESC) begin
            mode = MODE_ESC;
            push_plain(end_act, 8'h00, 1'b0);
          end else if (string_fill + 1 < STRING_BUF) begin
            string_fill++;
            push_plain(byte_act, b, 1'b0);
          end
        end
        MODE_APC: begin
          if (b == BYTE_BEL) mode = MODE_GROUND;
          else if (b == BYTE_ESC) mode = MODE_ESC;
        end
        default: mode = MODE_GROUND;
      endcase
    endfunction

    function void flag(string field, int unsigned want, int unsigned seen);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
      errors++;
    endfunction

    function void match_action(res_t got);
      res_t want;
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected action, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_actions.pop_front();
      if (got.action !== want.action) flag("action", want.action, got.action);
      if (got.data_byte !== want.data_byte) flag("data_byte", want.data_byte, got.data_byte);
      if (got.private_marker !== want.private_marker)
        flag("private_marker", want.private_marker, got.private_marker);
      if (got.trailing_byte !== want.trailing_byte)
        flag("trailing_byte", want.trailing_byte, got.trailing_byte);
      if (got.arg_index !== want.arg_index) flag("arg_index", want.arg_index, got.arg_index);
      if (got.arg_value !== want.arg_value) flag("arg_value", want.arg_value, got.arg_value);
      if (got.arg_colon !== want.arg_colon) flag("arg_colon", want.arg_colon, got.arg_colon);
      if (got.arg_count !== want.arg_count) flag("arg_count", want.arg_count, got.arg_count);
      if (got.bel_terminated !== want.bel_terminated)
        flag("bel_terminated", want.bel_terminated, got.bel_terminated);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  action;
  logic [7:0]  data_byte;
  logic [7:0]  private_marker;
  logic [7:0]  trailing_byte;
  logic [3:0]  arg_index;
  logic [15:0] arg_value;
  logic        arg_colon;
  logic [4:0]  arg_count;
  logic        bel_terminated;
  logic        last;

  parser_shadow shadow = new();
  int           bytes_sent = 0;
  bit           sender_steady = 1'b0;
  string        esc_finals = "c78DEM=>";
  string        esc_inters = "()*+-./#% ";
  string        csi_markers = "?>!=";

  terminal_escape_sequence_parser dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_in        (byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .action         (action),
    .data_byte      (data_byte),
    .private_marker (private_marker),
    .trailing_byte  (trailing_byte),
    .arg_index      (arg_index),
    .arg_value      (arg_value),
    .arg_colon      (arg_colon),
    .arg_count      (arg_count),
    .bel_terminated (bel_terminated),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL terminal_escape_sequence_parser");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    shadow.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sender goes quiet until the block has returned everything owed
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.outstanding() != 0);
  endtask

  task automatic send_random_sequence();
    int         pick;
    int         n;
    int         i;
    int         j;
    int         ndig;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    sender_steady = ($urandom_range(0, 5) == 0);
    if (pick < 35) begin
      // well-formed CSI with random content
      send_byte(BYTE_ESC);
      send_byte("[");
      if ($urandom_range(0, 2) == 0) send_byte(csi_markers[$urandom_range(0, 3)]);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
        for (j = 0; j < ndig; j++) send_byte(8'("0" + $urandom_range(0, 9)));
        if (i < n - 1) send_byte(($urandom_range(0, 3) == 0) ? ":" : ";");
      end
      if ($urandom_range(0, 4) == 0) begin
        b = 8'($urandom_range(8'h20, 8'h2F));
        send_byte(b);
      end
      b = 8'($urandom_range(FINAL_LO, FINAL_HI));
      send_byte(b);
    end else if (pick < 55) begin
      send_byte(BYTE_ESC);
      send_byte($urandom_range(0, 1) ? "]" : "P");
      n = $urandom_range(0, 10);
      for (i = 0; i < n; i++) begin
        b = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(8'h20, 8'h7E));
        send_byte(b);
      end
      if ($urandom_range(0, 1)) begin
        send_byte(BYTE_BEL);
      end else begin
        send_byte(BYTE_ESC);
        send_byte("\\");
      end
    end else if (pick < 60) begin
      send_byte(BYTE_ESC);
      send_byte($urandom_range(0, 1) ? "_" : "^");
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        send_byte(b);
      end
      send_byte($urandom_range(0, 1) ? BYTE_BEL : BYTE_ESC);
    end else if (pick < 70) begin
      send_byte(BYTE_ESC);
      case ($urandom_range(0, 2))
        0: send_byte(esc_finals[$urandom_range(0, 7)]);
        1: begin
          send_byte(esc_inters[$urandom_range(0, 9)]);
          b = 8'($urandom_range(0, 255));
          send_byte(b);
        end
        default: begin
          b = 8'($urandom_range(0, 255));
          send_byte(b);
        end
      endcase
    end else if (pick < 90) begin
      // text with control bytes mixed in
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        b = 8'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(8'h20, 8'h7E));
        send_byte(b);
      end
    end else begin
      // broken CSI: arbitrary bytes after the introducer
      send_byte(BYTE_ESC);
      send_byte("[");
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        send_byte(b);
      end
    end
  endtask

  // result side: random stall after each accepted result, one long hold-off
  initial begin : result_sink
    int   stall_left;
    int   hold_left;
    int   seen;
    bit   rx_steady;
    bit   held;
    res_t got;
    stall_left = 0;
    hold_left  = 0;
    seen       = 0;
    rx_steady  = 1'b0;
    held       = 1'b0;
    out_stall  = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_valid && !out_stall) begin
        got.action         = action_t'(action);
        got.data_byte      = data_byte;
        got.private_marker = private_marker;
        got.trailing_byte  = trailing_byte;
        got.arg_index      = arg_index;
        got.arg_value      = arg_value;
        got.arg_colon      = arg_colon;
        got.arg_count      = arg_count;
        got.bel_terminated = bel_terminated;
        got.last           = last;
        shadow.match_action(got);
        seen++;
        if (seen == 40 && !held) begin
          held      = 1'b1;
          hold_left = 150;
        end
        if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
        stall_left = rx_steady ? 0 : $urandom_range(0, 4);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int i;
    int random_end;
    int waited;
    bit paused;
    rst      = 1'b1;
    in_valid = 1'b0;
    byte_in  = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ground: byte extremes, every control, dropped bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(BYTE_DEL);
    send_text("A~");
    send_byte(BYTE_LF);
    send_byte(BYTE_VT);
    send_byte(BYTE_FF);
    send_byte(BYTE_CR);
    send_byte(BYTE_BS);
    send_byte(BYTE_TAB);
    send_byte(BYTE_BEL);
    send_byte(8'h1F);

    // an escape final, intermediate, ESC ESC and an unknown final
    send_byte(BYTE_ESC);
    send_text("c");
    send_byte(BYTE_ESC);
    send_text("(B");
    send_byte(BYTE_ESC);
    send_byte(BYTE_ESC);
    send_byte(BYTE_ESC);
    send_text("z");

    // CSI: marker, empty argument, colon, saturation, no parameter bytes
    send_byte(BYTE_ESC);
    send_text("[?1;;23:4m");
    send_byte(BYTE_ESC);
    send_text("[99999;65535:0H");
    send_byte(BYTE_ESC);
    send_text("[~");
    // control byte buffered inside CSI, intermediate before the final
    send_byte(BYTE_ESC);
    send_text("[1");
    send_byte(BYTE_LF);
    send_text("2 q");
    // more separators than argument slots
    send_byte(BYTE_ESC);
    send_byte("[");
    for (i = 0; i < 20; i++) send_byte(";");
    send_text("r");
    // buffer overflow aborts; the tail prints in ground
    send_byte(BYTE_ESC);
    send_byte("[");
    for (i = 0; i < 70; i++) send_byte("1");

    // strings: both terminators, APC and PM swallowed
    send_byte(BYTE_ESC);
    send_text("]0;title");
    send_byte(BYTE_BEL);
    send_byte(BYTE_ESC);
    send_text("P1$r");
    send_byte(BYTE_ESC);
    send_text("\\");
    send_byte(BYTE_ESC);
    send_text("_apc");
    send_byte(BYTE_BEL);
    send_byte(BYTE_ESC);
    send_text("^pm");
    send_byte(BYTE_ESC);
    send_text("\\");
    // string longer than the buffer: excess bytes dropped
    send_byte(BYTE_ESC);
    send_byte("]");
    for (i = 0; i < 260; i++) send_byte(8'($urandom_range(8'h20, 8'hFF)));
    send_byte(BYTE_BEL);

    pause_until_drained();

    random_end = bytes_sent + 60;
    paused     = 1'b0;
    while (bytes_sent < random_end) begin
      send_random_sequence();
      if (!paused && bytes_sent > random_end - 30) begin
        paused = 1'b1;
        pause_until_drained();
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (shadow.outstanding() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (shadow.outstanding() != 0) begin
      $display("%0t: %0d expected actions never arrived", $time, shadow.outstanding());
      shadow.errors++;
    end
    repeat (40) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("PASS terminal_escape_sequence_parser");
    end else begin
      $display("FAIL terminal_escape_sequence_parser");
    end
    $finish;
  end

endmodule
